// ===== rtl/xpfec_pkg.sv =====
// Package for the XOR parity FEC group encoder.
// Holds shared types, result codes and default sizes; no dependencies.
package xpfec_pkg;

    localparam int MAX_PACKET_BYTES_DEF  = 2048;
    localparam int GROUP_NUMBER_BITS_DEF = 16;

    localparam int BYTE_W  = 8;
    localparam int GSIZE_W = 8;
    localparam int GROUP_W = 16;   // width of the group number field on the port

    localparam logic [GSIZE_W-1:0] GROUP_SIZE_RESET = GSIZE_W'(4);

    typedef enum logic {
        CMD_DATA  = 1'b0,
        CMD_FETCH = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_PARITY = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_IDLE   = 2'd3
    } t_out_kind;

    // One item in flight between the store read and the output register
    typedef struct packed {
        t_out_kind            kind;
        logic [BYTE_W-1:0]    byte_val;   // input byte for data, zero otherwise
        logic [GROUP_W-1:0]   grp;
        logic                 done;
        logic                 last;
        logic                 ovf;
        logic                 rd_valid;   // entry lies below parity length
        logic                 wr;         // XOR result goes back to the store
    } t_s1;

endpackage

// ===== rtl/xpfec_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies; read data holds while read enable is low.
module xpfec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/xor_parity_fec_group_encoder.sv =====
// XOR parity FEC group encoder: each result passes through the stage 1 register, then the output register.
// Throughput 1 item per cycle while the receiver does not stall the output; the parity RAM is
// updated by read-modify-write (read port, write port, one-deep forward of the last write).
// Reset (sync, active low) clears all control, group number 1, group_size 4.
// No clearing pass: store entries at or above the parity length read as zero.
// Depends on xpfec_pkg and xpfec_ram.
module xor_parity_fec_group_encoder #(
    parameter int MAX_PACKET_BYTES  = xpfec_pkg::MAX_PACKET_BYTES_DEF,
    parameter int GROUP_NUMBER_BITS = xpfec_pkg::GROUP_NUMBER_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [xpfec_pkg::GSIZE_W-1:0]     i_cfg_wr_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cmd,
    input  logic [xpfec_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                              i_last_in_packet,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_out_kind,
    output logic [xpfec_pkg::BYTE_W-1:0]      o_out_byte,
    output logic [xpfec_pkg::GROUP_W-1:0]     o_group_number,
    output logic                              o_group_done,
    output logic                              o_parity_last,
    output logic                              o_length_overflow
);

    localparam int OFF_W  = $clog2(MAX_PACKET_BYTES + 1);
    localparam int ADDR_W = $clog2(MAX_PACKET_BYTES);
    localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_PACKET_BYTES);
    localparam logic [OFF_W-1:0] OFF_ONE = OFF_W'(1);

    // control state
    logic [OFF_W-1:0]                  r_off, n_off;
    logic [OFF_W-1:0]                  r_plen, n_plen;
    logic [OFF_W-1:0]                  r_drain, n_drain;
    logic [xpfec_pkg::GSIZE_W-1:0]     r_pig, n_pig;
    logic [xpfec_pkg::GSIZE_W-1:0]     r_gsize;
    logic [GROUP_NUMBER_BITS-1:0]      r_group, n_group;
    logic                              r_pending, n_pending;

    // stage 1 and forward
    logic                              r_s1_valid;
    xpfec_pkg::t_s1                    r_s1, n_s1;
    logic [ADDR_W-1:0]                 r_s1_addr, n_addr;
    logic                              r_fwd_valid;
    logic [ADDR_W-1:0]                 r_fwd_addr;
    logic [xpfec_pkg::BYTE_W-1:0]      r_fwd_data;

    // output register
    logic                              r_out_valid;
    xpfec_pkg::t_out_kind              r_out_kind;
    logic [xpfec_pkg::BYTE_W-1:0]      r_out_byte;
    logic [xpfec_pkg::GROUP_W-1:0]     r_out_grp;
    logic                              r_out_done;
    logic                              r_out_last;
    logic                              r_out_ovf;

    logic                              out_free;
    logic                              s1_adv;
    logic                              accept;
    logic [xpfec_pkg::BYTE_W-1:0]      ram_rd_data;
    logic [xpfec_pkg::BYTE_W-1:0]      rd_eff;
    logic [xpfec_pkg::BYTE_W-1:0]      wr_data;
    logic [xpfec_pkg::BYTE_W-1:0]      s1_out_byte;
    logic [xpfec_pkg::GSIZE_W-1:0]     pig_inc;
    logic [OFF_W-1:0]                  drain_inc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    // Stage 0: all scalar state but the group size moves at accept, the store read is issued
    always_comb begin
        n_off      = r_off;
        n_plen     = r_plen;
        n_drain    = r_drain;
        n_pig      = r_pig;
        n_group    = r_group;
        n_pending  = r_pending;
        pig_inc    = r_pig + xpfec_pkg::GSIZE_W'(1);
        drain_inc  = r_drain + OFF_ONE;
        n_addr     = r_off[ADDR_W-1:0];
        n_s1       = '0;
        n_s1.grp   = xpfec_pkg::GROUP_W'(r_group);
        n_s1.kind  = xpfec_pkg::KIND_IDLE;
        if (accept) begin
            case (xpfec_pkg::t_cmd'(i_cmd))
                xpfec_pkg::CMD_DATA: begin
                    n_addr = r_off[ADDR_W-1:0];
                    if (r_pending) begin
                        n_s1.kind = xpfec_pkg::KIND_REJECT;
                    end else begin
                        n_s1.kind     = xpfec_pkg::KIND_DATA;
                        n_s1.byte_val = i_data_byte;
                        if (r_off < OFF_MAX) begin
                            n_s1.rd_valid = r_off < r_plen;
                            n_s1.wr       = 1'b1;
                            if (r_off + OFF_ONE > r_plen) begin
                                n_plen = r_off + OFF_ONE;
                            end
                            n_off = r_off + OFF_ONE;
                        end else begin
                            n_s1.ovf = 1'b1;
                        end
                        if (i_last_in_packet) begin
                            n_off = '0;
                            if (pig_inc == r_gsize) begin
                                n_pig     = '0;
                                n_pending = 1'b1;
                                n_drain   = '0;
                                n_s1.done = 1'b1;
                            end else begin
                                n_pig = pig_inc;
                            end
                        end
                    end
                end
                xpfec_pkg::CMD_FETCH: begin
                    n_addr = r_drain[ADDR_W-1:0];
                    if (r_pending) begin
                        n_s1.kind     = xpfec_pkg::KIND_PARITY;
                        n_s1.rd_valid = r_drain < r_plen;
                        if (drain_inc >= r_plen) begin
                            // final parity byte: close the group
                            n_s1.last = 1'b1;
                            n_pending = 1'b0;
                            n_drain   = '0;
                            n_plen    = '0;
                            n_group   = r_group + GROUP_NUMBER_BITS'(1);
                        end else begin
                            n_drain = drain_inc;
                        end
                    end
                end
                default: begin
                    n_s1.kind = xpfec_pkg::KIND_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off      <= '0;
            r_plen     <= '0;
            r_drain    <= '0;
            r_pig      <= '0;
            r_group    <= GROUP_NUMBER_BITS'(1);
            r_pending  <= 1'b0;
            r_gsize    <= xpfec_pkg::GROUP_SIZE_RESET;
        end else begin
            r_off      <= n_off;
            r_plen     <= n_plen;
            r_drain    <= n_drain;
            r_pig      <= n_pig;
            r_group    <= n_group;
            r_pending  <= n_pending;
            if (i_cfg_wr_en) begin
                r_gsize <= i_cfg_wr_data;
            end
        end
    end

    xpfec_ram #(
        .WIDTH (xpfec_pkg::BYTE_W),
        .DEPTH (MAX_PACKET_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv && r_s1.wr),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (n_addr),
        .o_rd_data (ram_rd_data)
    );

    // Stage 1: read data arrives; the write of the previous item may not be in it yet
    always_comb begin
        if (!r_s1.rd_valid) begin
            rd_eff = '0;
        end else if (r_fwd_valid && r_fwd_addr == r_s1_addr) begin
            rd_eff = r_fwd_data;
        end else begin
            rd_eff = ram_rd_data;
        end
        wr_data     = rd_eff ^ r_s1.byte_val;
        s1_out_byte = (r_s1.kind == xpfec_pkg::KIND_PARITY) ? rd_eff : r_s1.byte_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_fwd_valid <= r_s1.wr;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1      <= n_s1;
            r_s1_addr <= n_addr;
        end
        if (s1_adv) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= wr_data;
            r_out_kind <= r_s1.kind;
            r_out_byte <= s1_out_byte;
            r_out_grp  <= r_s1.grp;
            r_out_done <= r_s1.done;
            r_out_last <= r_s1.last;
            r_out_ovf  <= r_s1.ovf;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_kind        = r_out_kind;
    assign o_out_byte        = r_out_byte;
    assign o_group_number    = r_out_grp;
    assign o_group_done      = r_out_done;
    assign o_parity_last     = r_out_last;
    assign o_length_overflow = r_out_ovf;

    // checks on the encoder state
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= OFF_MAX && r_off <= OFF_MAX)
        else $error("parity length or byte offset beyond store depth");

    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pending |-> r_drain == '0)
        else $error("drain offset nonzero with no parity pending");

    a_drain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> (r_drain < r_plen || r_drain == '0))
        else $error("drain offset past parity length");

    a_pending_pig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> r_pig == '0)
        else $error("packet count nonzero while parity pending");

    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == xpfec_pkg::CMD_DATA && r_pending)
            |=> ($stable(r_off) && $stable(r_plen) && r_pending))
        else $error("rejected data byte changed encoder state");

endmodule

// ===== bench/fec_parity_checker.sv =====
// Checker for the XOR parity FEC group encoder: keeps its own copy of the parity store
// and group state, predicts one result item per accepted input item and compares fields.
// Depends on xpfec_pkg.
module fec_parity_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [xpfec_pkg::GSIZE_W-1:0] i_cfg_wr_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_cmd,
    input  logic [xpfec_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                          i_last_in_packet,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [1:0]                    i_out_kind,
    input  logic [xpfec_pkg::BYTE_W-1:0]  i_out_byte,
    input  logic [xpfec_pkg::GROUP_W-1:0] i_group_number,
    input  logic                          i_group_done,
    input  logic                          i_parity_last,
    input  logic                          i_length_overflow,
    input  logic                          i_end_of_test,
    output int                            o_fail_count
);

    localparam int DEPTH = xpfec_pkg::MAX_PACKET_BYTES_DEF;
    localparam int OFF_W = $clog2(DEPTH) + 1;     // must hold DEPTH itself

    typedef struct {
        xpfec_pkg::t_out_kind          kind;
        logic [xpfec_pkg::BYTE_W-1:0]  val;
        logic [xpfec_pkg::GROUP_W-1:0] grp;
        logic                          done;
        logic                          plast;
        logic                          ovf;
    } t_fec_result;

    logic [xpfec_pkg::BYTE_W-1:0]  parity_mem [DEPTH];
    logic [OFF_W-1:0]              wr_offset;
    logic [OFF_W-1:0]              parity_len;
    logic [OFF_W-1:0]              rd_offset;
    logic [xpfec_pkg::GSIZE_W-1:0] pkt_count;
    logic [xpfec_pkg::GSIZE_W-1:0] group_size;
    logic [xpfec_pkg::GROUP_W-1:0] group_num;
    logic                          parity_ready;

    t_fec_result expected_results[$];
    int          n_fail = 0;
    bit          end_seen = 1'b0;

    assign o_fail_count = n_fail;

    task automatic clear_encoder_state();
        int k;
        for (k = 0; k < DEPTH; k++)
            parity_mem[k] = '0;
        wr_offset    = '0;
        parity_len   = '0;
        rd_offset    = '0;
        pkt_count    = '0;
        group_num    = xpfec_pkg::GROUP_W'(1);
        parity_ready = 1'b0;
        group_size   = xpfec_pkg::GROUP_SIZE_RESET;
        expected_results.delete();
    endtask

    function automatic t_fec_result encode_item(logic cmd, logic [xpfec_pkg::BYTE_W-1:0] d,
                                                logic last);
        t_fec_result r;
        r.kind  = xpfec_pkg::KIND_DATA;
        r.val   = '0;
        r.grp   = group_num;
        r.done  = 1'b0;
        r.plast = 1'b0;
        r.ovf   = 1'b0;
        if (cmd == xpfec_pkg::CMD_DATA) begin
            if (parity_ready) begin
                r.kind = xpfec_pkg::KIND_REJECT;
            end else begin
                r.val = d;
                if (wr_offset < DEPTH) begin
                    parity_mem[wr_offset] = parity_mem[wr_offset] ^ d;
                    if (wr_offset + 1'b1 > parity_len)
                        parity_len = wr_offset + 1'b1;
                    wr_offset = wr_offset + 1'b1;
                end else begin
                    r.ovf = 1'b1;   // offset stays saturated at the store depth
                end
                if (last) begin
                    wr_offset = '0;
                    pkt_count = pkt_count + 1'b1;   // 8-bit wrap: size 0 means 256
                    if (pkt_count == group_size) begin
                        pkt_count    = '0;
                        parity_ready = 1'b1;
                        rd_offset    = '0;
                        r.done       = 1'b1;
                    end
                end
            end
        end else if (!parity_ready) begin
            r.kind = xpfec_pkg::KIND_IDLE;
        end else begin
            r.kind = xpfec_pkg::KIND_PARITY;
            if (rd_offset < DEPTH && rd_offset < parity_len) begin
                r.val = parity_mem[rd_offset];
                parity_mem[rd_offset] = '0;
            end
            rd_offset = rd_offset + 1'b1;
            if (rd_offset >= parity_len) begin
                r.plast      = 1'b1;
                parity_ready = 1'b0;
                rd_offset    = '0;
                parity_len   = '0;
                group_num    = group_num + 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_fec_result r;
        if (!i_rst_n) begin
            clear_encoder_state();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected");
                    n_fail++;
                end else begin
                    r = expected_results.pop_front();
                    check_field("out_kind", 32'(r.kind), 32'(i_out_kind));
                    check_field("out_byte", 32'(r.val), 32'(i_out_byte));
                    check_field("group_number", 32'(r.grp), 32'(i_group_number));
                    check_field("group_done", 32'(r.done), 32'(i_group_done));
                    check_field("parity_last", 32'(r.plast), 32'(i_parity_last));
                    check_field("length_overflow", 32'(r.ovf), 32'(i_length_overflow));
                end
            end
            if (i_cfg_wr_en)
                group_size = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(encode_item(i_cmd, i_data_byte, i_last_in_packet));
            if (i_end_of_test && !end_seen) begin
                end_seen = 1'b1;
                if (expected_results.size() != 0) begin
                    $error("%0d result items never arrived", expected_results.size());
                    n_fail += expected_results.size();
                end
            end
        end
    end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the XOR parity FEC group encoder: clock, reset, item stimulus
// with sender gaps and receiver stalls, and the verdict.
// Depends on xpfec_pkg, xor_parity_fec_group_encoder and fec_parity_checker.
module tb;

    localparam int DEPTH       = xpfec_pkg::MAX_PACKET_BYTES_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [xpfec_pkg::GSIZE_W-1:0] i_cfg_wr_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          i_cmd = 1'b0;
    logic [xpfec_pkg::BYTE_W-1:0]  i_data_byte = '0;
    logic                          i_last_in_packet = 1'b0;
    logic                          i_out_stall = 1'b0;
    logic                          end_of_test = 1'b0;

    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [1:0]                    o_out_kind;
    logic [xpfec_pkg::BYTE_W-1:0]  o_out_byte;
    logic [xpfec_pkg::GROUP_W-1:0] o_group_number;
    logic                          o_group_done;
    logic                          o_parity_last;
    logic                          o_length_overflow;
    int                            fail_count;

    int  send_gap_pct = 7;
    int  recv_stall_pct = 47;
    int  hold_target = 0;       // receiver holds stall until its own count reaches this
    int  hold_done = 0;
    int  n_sent = 0;
    int  n_recv = 0;
    int  cycle_count = 0;
    int  groups_drained = 0;
    bit  valid_up = 1'b0;

    // shape of the traffic, so packets and drains line up with the groups
    logic [xpfec_pkg::GSIZE_W-1:0] gsize_trk = xpfec_pkg::GROUP_SIZE_RESET;
    logic [xpfec_pkg::GSIZE_W-1:0] pkt_cnt_trk = '0;
    int                            parity_len_trk = 0;

    always #5 i_clk = ~i_clk;

    xor_parity_fec_group_encoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_data_byte      (i_data_byte),
        .i_last_in_packet (i_last_in_packet),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_kind       (o_out_kind),
        .o_out_byte       (o_out_byte),
        .o_group_number   (o_group_number),
        .o_group_done     (o_group_done),
        .o_parity_last    (o_parity_last),
        .o_length_overflow(o_length_overflow)
    );

    fec_parity_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_data_byte      (i_data_byte),
        .i_last_in_packet (i_last_in_packet),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_out_kind       (o_out_kind),
        .i_out_byte       (o_out_byte),
        .i_group_number   (o_group_number),
        .i_group_done     (o_group_done),
        .i_parity_last    (o_parity_last),
        .i_length_overflow(o_length_overflow),
        .i_end_of_test    (end_of_test),
        .o_fail_count     (fail_count)
    );

    always @(negedge i_clk) begin
        if (hold_done < hold_target) begin
            i_out_stall <= 1'b1;
            hold_done++;
        end else begin
            i_out_stall <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            n_recv++;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic put_item(xpfec_pkg::t_cmd c, logic [xpfec_pkg::BYTE_W-1:0] d, logic l);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            if (valid_up) begin
                i_in_valid <= 1'b0;
                valid_up = 1'b0;
            end
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        valid_up         = 1'b1;
        i_cmd            <= c;
        i_data_byte      <= d;
        i_last_in_packet <= l;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        if (valid_up) begin
            i_in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (n_recv != n_sent)
            @(negedge i_clk);
    endtask

    // only called once every result is back
    task automatic write_group_size(logic [xpfec_pkg::GSIZE_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        gsize_trk = v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // noise while pending is rejected data, so the drain itself is untouched
    task automatic drain_parity(int noise_pct);
        int k;
        for (k = 0; k < parity_len_trk; k++) begin
            if (noise_pct != 0 && $urandom_range(99) < noise_pct)
                put_item(xpfec_pkg::CMD_DATA, xpfec_pkg::BYTE_W'($urandom), 1'($urandom));
            put_item(xpfec_pkg::CMD_FETCH, xpfec_pkg::BYTE_W'($urandom), 1'($urandom));
        end
        parity_len_trk = 0;
        groups_drained++;
        if (noise_pct != 0 && $urandom_range(99) < noise_pct)
            put_item(xpfec_pkg::CMD_FETCH, xpfec_pkg::BYTE_W'($urandom), 1'($urandom));
    endtask

    // noise inside a packet is a fetch with nothing pending, which changes no state
    task automatic send_packet(int len, int noise_pct);
        int i;
        int stored;
        for (i = 0; i < len; i++) begin
            if (noise_pct != 0 && $urandom_range(99) < noise_pct)
                put_item(xpfec_pkg::CMD_FETCH, xpfec_pkg::BYTE_W'($urandom), 1'($urandom));
            put_item(xpfec_pkg::CMD_DATA, xpfec_pkg::BYTE_W'($urandom), i == len - 1);
        end
        stored = (len > DEPTH) ? DEPTH : len;
        if (stored > parity_len_trk)
            parity_len_trk = stored;
        pkt_cnt_trk = pkt_cnt_trk + 1'b1;
        if (pkt_cnt_trk == gsize_trk) begin
            pkt_cnt_trk = '0;
            drain_parity(noise_pct);
        end
    endtask

    task automatic random_traffic(int n_items);
        int stop;
        int r;
        int len;
        stop = n_sent + n_items;
        wait_idle();
        write_group_size(xpfec_pkg::GSIZE_W'(pkt_cnt_trk + $urandom_range(1, 6)));
        while (n_sent < stop) begin
            r = $urandom_range(99);
            len = (r < 70) ? $urandom_range(1, 6) :
                  (r < 95) ? $urandom_range(7, 40) : $urandom_range(41, 300);
            if ($urandom_range(99) < 90)
                send_packet(len, 10);
            else
                put_item(xpfec_pkg::CMD_FETCH, xpfec_pkg::BYTE_W'($urandom), 1'($urandom));
        end
    endtask

    // one-byte packets keep the large groups short
    task automatic finish_one_group();
        int start;
        start = groups_drained;
        while (groups_drained == start)
            send_packet(1, 5);
    endtask

    initial begin
        int k;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default group size of 4, corner bytes, reject and idle cases
        put_item(xpfec_pkg::CMD_FETCH, 8'h00, 1'b0);
        put_item(xpfec_pkg::CMD_DATA, 8'h00, 1'b0);
        put_item(xpfec_pkg::CMD_DATA, 8'hFF, 1'b0);
        put_item(xpfec_pkg::CMD_DATA, 8'hA5, 1'b1);
        put_item(xpfec_pkg::CMD_DATA, 8'h5A, 1'b1);
        put_item(xpfec_pkg::CMD_DATA, 8'hFF, 1'b0);
        put_item(xpfec_pkg::CMD_DATA, 8'h01, 1'b1);
        put_item(xpfec_pkg::CMD_DATA, 8'h80, 1'b1);
        put_item(xpfec_pkg::CMD_DATA, 8'h77, 1'b1);
        for (k = 0; k < 3; k++)
            put_item(xpfec_pkg::CMD_FETCH, 8'hFF, 1'b1);
        put_item(xpfec_pkg::CMD_FETCH, 8'h00, 1'b0);
        wait_idle();
        write_group_size(xpfec_pkg::GSIZE_W'(1));
        put_item(xpfec_pkg::CMD_DATA, 8'h3C, 1'b1);
        put_item(xpfec_pkg::CMD_DATA, 8'hC3, 1'b0);
        put_item(xpfec_pkg::CMD_FETCH, 8'h00, 1'b0);
        groups_drained = 2;

        random_traffic(150);

        // long receiver hold while the sender keeps offering items
        hold_target = hold_done + 300;
        k = n_sent + 60;
        while (n_sent < k)
            send_packet($urandom_range(1, 8), 10);
        wait_idle();

        send_gap_pct   = 47;
        recv_stall_pct = 7;
        random_traffic(150);

        // largest nonzero group size
        wait_idle();
        write_group_size(xpfec_pkg::GSIZE_W'(255));
        finish_one_group();

        send_gap_pct   = 0;
        recv_stall_pct = 0;

        // size 0 counts 256 packets
        wait_idle();
        write_group_size(xpfec_pkg::GSIZE_W'(0));
        finish_one_group();

        // lowering the size below the count makes the counter run on through its wrap
        wait_idle();
        write_group_size(xpfec_pkg::GSIZE_W'(10));
        for (k = 0; k < 5; k++)
            send_packet($urandom_range(1, 3), 0);
        wait_idle();
        write_group_size(xpfec_pkg::GSIZE_W'(3));
        finish_one_group();

        wait_idle();
        repeat (20) @(negedge i_clk);
        end_of_test <= 1'b1;
        repeat (2) @(negedge i_clk);

        $display("%0d items sent, %0d parity packets drained", n_sent, groups_drained);
        $display("group sizes 1 to 6, 255, 0 and lowered mid-group, rejects, idle fetches");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
